// ----- hw/rtl/sacs_pkg.sv -----
// Shared constants, types and codes of the SRRIP set-associative tag store.
package sacs_pkg;

  // Geometry
  localparam int WAYS = 4;
  localparam int SETS = 256;

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 8;
  localparam int RRPV_W    = 2;
  localparam int OUT_WAY_W = 2;
  localparam int SHIFT_W   = 5;

  // Set number before the wrap to SETS: index_bits is at most 15
  localparam int RAW_W = 15;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);

  // Reciprocal for the wrap when SETS is not a power of two
  localparam int DIV_K = RAW_W + SET_W;
  localparam int DIV_M = (2 ** DIV_K) / SETS;
  localparam int M_W   = DIV_K + 1;

  // Re-reference values
  localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_FILL = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_HIT  = 2'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 8'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] OFFSET_RST = 4'd6;
  localparam logic [CFG_W-1:0] INDEX_RST  = 4'd8;

  typedef logic [TAG_W-1:0] tag_t;

  typedef struct packed {
    logic              valid;
    logic [RRPV_W-1:0] rrpv;
  } meta_t;

  // Outcome of one lookup
  typedef struct packed {
    logic             hit;
    logic             filled_empty;
    logic [WAY_W-1:0] way;
  } dec_t;

  localparam int META_ROW_W = WAYS * $bits(meta_t);
  localparam int TAG_ROW_W  = WAYS * TAG_W;

endpackage

// ----- hw/rtl/sacs_if.sv -----
// Valid/ready channel interfaces: access requests, results and register writes.
interface sacs_req_if;
  logic                        valid;
  logic                        ready;
  logic [sacs_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [sacs_pkg::OUT_WAY_W-1:0] way_used;
  logic                           filled_empty;

  modport source (output valid, output hit, output way_used, output filled_empty,
                  input ready);
  modport sink   (input valid, input hit, input way_used, input filled_empty,
                  output ready);
endinterface

interface sacs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sacs_pkg::CFG_IDX_W-1:0] index;
  logic [sacs_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/sacs_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module sacs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/sacs_way_sel.sv -----
// Way selection for one set: hit search, empty-way fill, SRRIP ageing and victim.
module sacs_way_sel (
  input  sacs_pkg::tag_t              tag,
  input  sacs_pkg::tag_t [sacs_pkg::WAYS-1:0] tag_row,
  input  sacs_pkg::meta_t [sacs_pkg::WAYS-1:0] meta_row,
  output sacs_pkg::dec_t              dec,
  output sacs_pkg::meta_t [sacs_pkg::WAYS-1:0] meta_new,
  output sacs_pkg::tag_t [sacs_pkg::WAYS-1:0] tag_new
);
  import sacs_pkg::*;

  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   inv_vec;
  logic [WAYS-1:0]   max_vec;
  logic [WAYS-1:0]   is3;
  logic [WAYS-1:0]   is2;
  logic [WAYS-1:0]   is1;
  logic [RRPV_W-1:0] maxv;
  logic [RRPV_W-1:0] delta;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  vic_way;

  // Per-way match flags
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = meta_row[w].valid && (tag_row[w] == tag);
      inv_vec[w] = !meta_row[w].valid;
      is3[w]     = (meta_row[w].rrpv == 2'd3);
      is2[w]     = (meta_row[w].rrpv == 2'd2);
      is1[w]     = (meta_row[w].rrpv == 2'd1);
    end
  end

  // Largest value in the set, and the ageing step that lifts it to the maximum
  always_comb begin
    if (|is3) begin
      maxv = 2'd3;
    end else if (|is2) begin
      maxv = 2'd2;
    end else if (|is1) begin
      maxv = 2'd1;
    end else begin
      maxv = 2'd0;
    end
    delta = RRPV_MAX - maxv;
    for (int w = 0; w < WAYS; w++) begin
      max_vec[w] = (meta_row[w].rrpv == maxv);
    end
  end

  // Lowest-numbered way of each kind
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    vic_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (inv_vec[w]) inv_way = WAY_W'(w);
      if (max_vec[w]) vic_way = WAY_W'(w);
    end
  end

  // Decision and updated row
  always_comb begin
    meta_new = meta_row;
    tag_new  = tag_row;
    dec.hit  = |hit_vec;
    if (|hit_vec) begin
      dec.filled_empty       = 1'b0;
      dec.way                = hit_way;
      meta_new[hit_way].rrpv = RRPV_HIT;
    end else if (|inv_vec) begin
      dec.filled_empty        = 1'b1;
      dec.way                 = inv_way;
      meta_new[inv_way].valid = 1'b1;
      meta_new[inv_way].rrpv  = RRPV_FILL;
      tag_new[inv_way]        = tag;
    end else begin
      dec.filled_empty = 1'b0;
      dec.way          = vic_way;
      for (int w = 0; w < WAYS; w++) begin
        meta_new[w].rrpv = meta_row[w].rrpv + delta;
      end
      meta_new[vic_way].rrpv = RRPV_FILL;
      tag_new[vic_way]       = tag;
    end
  end

endmodule

// ----- hw/rtl/set_assoc_cache_srrip.sv -----
// Steps per access: the set read, then evaluate and write-back, then the result register; when SETS
// is not a power of 2, the set wrap steps (reciprocal multiply, correction) come before the set read.
// A new request is taken only after the write-back of the previous one, which waits while a result is held.
// Reset: synchronous, active high; registers return to offset_bits=6, index_bits=8.
// After reset a clearing pass over all SETS rows marks every way invalid with value 3;
// requests wait during the pass, register writes are taken throughout.
module set_assoc_cache_srrip (
  input  logic           clk,
  input  logic           rst,
  sacs_req_if.sink       req,
  sacs_rsp_if.source     rsp,
  sacs_cfg_if.sink       cfg
);
  import sacs_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CFG_W-1:0] offset_bits;
  logic [CFG_W-1:0] index_bits;
  logic [SET_W-1:0] clr_cnt;

  logic                  accept;
  logic [ADDR_W-1:0]     shifted;
  logic [RAW_W-1:0]      idx_mask;
  logic [RAW_W-1:0]      raw_in;
  logic [SHIFT_W-1:0]    tag_shift;
  tag_t                  tag_in;
  logic [SET_W-1:0]      set_pow2;

  tag_t                  tag_reg;
  logic [RAW_W-1:0]      raw_reg;
  logic [RAW_W-1:0]      q_reg;
  logic [SET_W-1:0]      set_reg;

  logic [RAW_W+M_W-1:0]  div_prod;
  logic [RAW_W-1:0]      q_sets;
  logic [RAW_W-1:0]      rem_full;
  logic [RAW_W-1:0]      rem_fix;
  logic [SET_W-1:0]      set_div;

  logic                  rd_en;
  logic [SET_W-1:0]      rd_addr;
  logic                  commit;
  logic                  meta_we;
  logic [SET_W-1:0]      meta_waddr;
  meta_t [WAYS-1:0]      meta_wdata;
  meta_t [WAYS-1:0]      meta_clr;
  meta_t [WAYS-1:0]      meta_row;
  meta_t [WAYS-1:0]      meta_new;
  tag_t  [WAYS-1:0]      tag_row;
  tag_t  [WAYS-1:0]      tag_new;
  dec_t                  dec;

  logic                  out_valid;
  logic                  out_hit;
  logic [OUT_WAY_W-1:0]  out_way;
  logic                  out_filled;

  // Register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_RST;
      index_bits  <= INDEX_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_OFFSET_BITS: offset_bits <= cfg.data;
        CFG_INDEX_BITS:  index_bits  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Address split
  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign shifted   = req.address >> offset_bits;
  assign idx_mask  = ~({RAW_W{1'b1}} << index_bits);
  assign raw_in    = shifted[RAW_W-1:0] & idx_mask;
  assign tag_shift = SHIFT_W'(offset_bits) + SHIFT_W'(index_bits);
  assign tag_in    = req.address >> tag_shift;
  assign set_pow2  = SET_W'(raw_in & RAW_W'(SETS - 1));

  // Set wrap by reciprocal multiply and one correction
  assign div_prod = (RAW_W+M_W)'(raw_reg) * (RAW_W+M_W)'(DIV_M);
  assign q_sets   = RAW_W'(q_reg * RAW_W'(SETS));
  assign rem_full = raw_reg - q_sets;
  assign rem_fix  = (rem_full >= RAW_W'(SETS)) ? (rem_full - RAW_W'(SETS)) : rem_full;
  assign set_div  = SET_W'(rem_fix);

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_reg <= tag_in;
      raw_reg <= raw_in;
    end
    if (state == S_DIV) begin
      q_reg <= div_prod[DIV_K +: RAW_W];
    end
    if (rd_en) begin
      set_reg <= rd_addr;
    end
  end

  // Set read and write-back
  assign rd_en   = (accept && SETS_POW2) || (state == S_READ);
  assign rd_addr = (state == S_READ) ? set_div : set_pow2;
  assign commit  = (state == S_EVAL) && (!out_valid || rsp.ready);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      meta_clr[w].valid = 1'b0;
      meta_clr[w].rrpv  = RRPV_MAX;
    end
  end

  assign meta_we    = (state == S_CLEAR) || commit;
  assign meta_waddr = (state == S_CLEAR) ? clr_cnt : set_reg;
  assign meta_wdata = (state == S_CLEAR) ? meta_clr : meta_new;

  sacs_ram #(.WIDTH(META_ROW_W), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (meta_row)
  );

  sacs_ram #(.WIDTH(TAG_ROW_W), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (commit && !dec.hit),
    .waddr (set_reg),
    .wdata (tag_new),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (tag_row)
  );

  sacs_way_sel u_way_sel (
    .tag      (tag_reg),
    .tag_row  (tag_row),
    .meta_row (meta_row),
    .dec      (dec),
    .meta_new (meta_new),
    .tag_new  (tag_new)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == SET_W'(SETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = SETS_POW2 ? S_EVAL : S_DIV;
      S_DIV:   state_next = S_READ;
      S_READ:  state_next = S_EVAL;
      S_EVAL:  if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit    <= dec.hit;
      out_way    <= OUT_WAY_W'(dec.way);
      out_filled <= dec.filled_empty;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.way_used     = out_way;
  assign rsp.filled_empty = out_filled;

  // Checks
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && meta_we))
    else $error("set read and write-back in the same cycle");

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EVAL))
    else $error("result loaded outside the evaluate step");

  a_hit_not_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_filled))
    else $error("result reports both hit and empty fill");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !$past(accept))
    else $error("request taken during clearing pass");

endmodule

// ----- tb/set_assoc_cache_srrip_test.sv -----
// Testbench for set_assoc_cache_srrip: SRRIP tag-store predictor, random traffic and stalls.
`timescale 1ns / 1ps

module set_assoc_cache_srrip_test;
  import sacs_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASES          = 11;
  localparam int PHASE_ACCESSES  = 180;
  localparam int DIRECTED_COUNT  = 13;
  localparam int MAX_POOL_SETS   = 4;
  localparam int MAX_POOL_TAGS   = 9;
  localparam int NOISE_PCT       = 15;
  localparam int RANDOM_CFG      = -1;

  // Register indexes that map to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST = CFG_INDEX_BITS + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LAST  = '1;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way_used;
    logic                 filled_empty;
  } access_outcome_t;

  // Tag store predictor and the queue of outcomes still owed by the block
  class srrip_lookup_board;
    logic [TAG_W-1:0]  tag_mem    [SETS*WAYS];
    bit                line_valid [SETS*WAYS];
    logic [RRPV_W-1:0] rrpv       [SETS*WAYS];
    logic [CFG_W-1:0]  offset_bits;
    logic [CFG_W-1:0]  index_bits;
    access_outcome_t   due_outcomes [$];
    int unsigned       error_count;

    function new();
      for (int e = 0; e < SETS*WAYS; e++) begin
        tag_mem[e]    = '0;
        line_valid[e] = 1'b0;
        rrpv[e]       = RRPV_MAX;
      end
      offset_bits = OFFSET_RST;
      index_bits  = INDEX_RST;
      error_count = 0;
    endfunction

    function void take_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_OFFSET_BITS: offset_bits = value;
        CFG_INDEX_BITS:  index_bits = value;
        default: ;
      endcase
    endfunction

    function void take_access(logic [ADDR_W-1:0] addr);
      int unsigned       set_no;
      int unsigned       base;
      int unsigned       victim;
      int                shift;
      logic [TAG_W-1:0]  tag;
      logic [RRPV_W-1:0] top;
      logic [RRPV_W-1:0] bump;
      access_outcome_t   outc;
      shift  = int'(offset_bits) + int'(index_bits);
      set_no = (32'(addr) >> offset_bits) & ((32'd1 << index_bits) - 32'd1);
      set_no = set_no % SETS;
      tag    = addr >> shift;
      base   = set_no * WAYS;
      // hit: promote to near re-reference
      for (int w = 0; w < WAYS; w++) begin
        if (line_valid[base+w] && tag_mem[base+w] == tag) begin
          rrpv[base+w] = RRPV_HIT;
          outc = '{hit: 1'b1, way_used: OUT_WAY_W'(w), filled_empty: 1'b0};
          due_outcomes.push_back(outc);
          return;
        end
      end
      // miss into an empty way
      for (int w = 0; w < WAYS; w++) begin
        if (!line_valid[base+w]) begin
          tag_mem[base+w]    = tag;
          line_valid[base+w] = 1'b1;
          rrpv[base+w]       = RRPV_FILL;
          outc = '{hit: 1'b0, way_used: OUT_WAY_W'(w), filled_empty: 1'b1};
          due_outcomes.push_back(outc);
          return;
        end
      end
      // eviction: age the whole set in one step, take the first way at max
      top = '0;
      for (int w = 0; w < WAYS; w++)
        if (rrpv[base+w] > top) top = rrpv[base+w];
      bump   = RRPV_MAX - top;
      victim = WAYS;
      for (int w = 0; w < WAYS; w++) begin
        rrpv[base+w] = rrpv[base+w] + bump;
        if (victim == WAYS && rrpv[base+w] == RRPV_MAX) victim = w;
      end
      tag_mem[base+victim]    = tag;
      line_valid[base+victim] = 1'b1;
      rrpv[base+victim]       = RRPV_FILL;
      outc = '{hit: 1'b0, way_used: OUT_WAY_W'(victim), filled_empty: 1'b0};
      due_outcomes.push_back(outc);
    endfunction

    function void check_result(logic hit, logic [OUT_WAY_W-1:0] way_used,
                               logic filled_empty);
      access_outcome_t want;
      if (due_outcomes.size() == 0) begin
        $error("result with no access pending: hit=%0b way_used=%0d filled_empty=%0b",
               hit, way_used, filled_empty);
        error_count++;
        return;
      end
      want = due_outcomes.pop_front();
      if (hit !== want.hit) begin
        $error("hit: expected %0b, got %0b", want.hit, hit);
        error_count++;
      end
      if (way_used !== want.way_used) begin
        $error("way_used: expected %0d, got %0d", want.way_used, way_used);
        error_count++;
      end
      if (filled_empty !== want.filled_empty) begin
        $error("filled_empty: expected %0b, got %0b", want.filled_empty, filled_empty);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sacs_req_if req_ch ();
  sacs_rsp_if rsp_ch ();
  sacs_cfg_if cfg_ch ();

  set_assoc_cache_srrip dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  srrip_lookup_board board = new();

  // sender pacing
  int unsigned burst_left = 0;
  bit          idle_free  = 1'b0;

  always #CLK_HALF clk = ~clk;

  // Result side: random ready, with a stall level re-drawn from stall_plan at regular intervals
  initial begin
    int unsigned cyc;
    int unsigned stall_pct;
    int          stall_plan [5] = '{0, 0, 25, 60, 90};
    cyc = 0;
    stall_pct = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc % 48 == 0) stall_pct = stall_plan[$urandom_range(0, 4)];
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      cyc++;
    end
  end

  // Result check on every transfer
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board.check_result(rsp_ch.hit, rsp_ch.way_used, rsp_ch.filled_empty);
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("set_assoc_cache_srrip_test: FAIL");
    $finish;
  end

  // One access transfer; bursts of random length, random gaps between them unless idle_free is set
  task automatic push_access(input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    req_ch.valid   <= 1'b1;
    req_ch.address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    board.take_access(addr);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = idle_free ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop requesting and wait until the block has nothing left in flight
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (board.due_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.take_register(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Traffic on a few sets with a few competing tags, plus random noise
  task automatic run_phase(input int count);
    logic [31:0]      set_pool [MAX_POOL_SETS];
    logic [TAG_W-1:0] tag_pool [MAX_POOL_TAGS];
    int unsigned      n_sets;
    int unsigned      n_tags;
    int               shift;
    logic [31:0]      set_mask;
    logic [31:0]      low_mask;
    logic [ADDR_W-1:0] addr;
    n_sets   = $urandom_range(1, MAX_POOL_SETS);
    n_tags   = $urandom_range(2, MAX_POOL_TAGS);
    shift    = int'(board.offset_bits) + int'(board.index_bits);
    set_mask = (32'd1 << board.index_bits) - 32'd1;
    low_mask = (32'd1 << board.offset_bits) - 32'd1;
    for (int s = 0; s < MAX_POOL_SETS; s++) set_pool[s] = $urandom & set_mask;
    for (int t = 0; t < MAX_POOL_TAGS; t++) tag_pool[t] = $urandom;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < NOISE_PCT) begin
        addr = $urandom;
      end else begin
        // now and then a tag is replaced to keep misses coming
        if ($urandom_range(0, 19) == 0) tag_pool[$urandom_range(0, n_tags - 1)] = $urandom;
        addr = (tag_pool[$urandom_range(0, n_tags - 1)] << shift)
             | (set_pool[$urandom_range(0, n_sets - 1)] << board.offset_bits)
             | ($urandom & low_mask);
      end
      push_access(addr);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] directed_addrs [DIRECTED_COUNT] = '{
      32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0000_8000,
      32'h0000_C000, 32'h0001_0000, 32'h0000_0000, 32'h0000_4000, 32'hFFFF_FFC5,
      32'h0000_8000, 32'h0000_C000, 32'h0000_0020
    };
    int off_plan [PHASES] = '{0, 12, 15, 3, 0, 9, 2, 13, 6, RANDOM_CFG, RANDOM_CFG};
    int ib_plan  [PHASES] = '{0, 8, 15, 2, 8, 9, 15, 4, 8, RANDOM_CFG, RANDOM_CFG};
    logic [CFG_W-1:0] off_val;
    logic [CFG_W-1:0] ib_val;

    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.address <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // unmapped register write while the clearing pass runs
    write_reg(CFG_UNMAPPED_LAST, 4'hF);

    // Directed: extremes, hits, fills, ageing and evictions on reset split
    idle_free = 1'b1;
    for (int i = 0; i < DIRECTED_COUNT; i++) push_access(directed_addrs[i]);
    settle();

    // Random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      off_val = (off_plan[p] == RANDOM_CFG) ? CFG_W'($urandom_range(0, 15)) : CFG_W'(off_plan[p]);
      ib_val  = (ib_plan[p] == RANDOM_CFG) ? CFG_W'($urandom_range(0, 15)) : CFG_W'(ib_plan[p]);
      write_reg(CFG_OFFSET_BITS, off_val);
      write_reg(CFG_INDEX_BITS, ib_val);
      write_reg(CFG_IDX_W'($urandom_range(CFG_UNMAPPED_FIRST, CFG_UNMAPPED_LAST)),
                CFG_W'($urandom));
      idle_free = (p % 3 == 1);
      run_phase(PHASE_ACCESSES);
      settle();
    end

    if (board.error_count == 0) begin
      $display("set_assoc_cache_srrip_test: PASS");
    end else begin
      $display("set_assoc_cache_srrip_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sacs_pkg.sv
hw/rtl/sacs_if.sv
hw/rtl/sacs_ram.sv
hw/rtl/sacs_way_sel.sv
hw/rtl/set_assoc_cache_srrip.sv
tb/set_assoc_cache_srrip_test.sv
